/* rtl/bhp_pkg.sv */
// Shared widths, types and register codes of the biquad high-pass filter.
package bhp_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_FRAC_BITS = 16;
   localparam int STATE_BITS     = 40;
   localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
   localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
   // Two guard bits over the wider of a state and a product hold every sum exactly.
   localparam int ACC_BITS       = ((STATE_BITS > PROD_BITS) ? STATE_BITS : PROD_BITS) + 2;
   localparam int NUM_COEFS      = 5;
   localparam int CSR_INDEX_BITS = $clog2(NUM_COEFS);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [STATE_BITS-1:0]  state_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      COEF_B0 = CSR_INDEX_BITS'(0),
      COEF_B1 = CSR_INDEX_BITS'(1),
      COEF_B2 = CSR_INDEX_BITS'(2),
      COEF_A1 = CSR_INDEX_BITS'(3),
      COEF_A2 = CSR_INDEX_BITS'(4)
   } coef_index_type;

   localparam coef_type COEF_B0_RESET = coef_type'(1 << COEF_FRAC_BITS);

   // One command to the shared multiply-accumulate unit.
   typedef struct packed {
      logic       en;
      logic       sub;
      coef_type   coef;
      sample_type data;
      acc_type    base;
   } mac_op_type;

endpackage

/* rtl/biquad_highpass_filter.sv */
// Top level of the biquad filter: coefficient registers, delay states and the sequencer.
//
// Transposed direct form II biquad on signed 16-bit samples, coefficients in Q2.16.
// Request channel: req_valid / req_stall carry req_sample_in. A request is taken only
// while the sequencer is idle; req_stall is high for the whole of a computation.
// Response channel: rsp_valid / rsp_stall carry rsp_sample_out and rsp_clipped from an
// output register, so the next request is taken while a response still waits.
// A request passes through six sequencer steps after the idle state, since all
// five products go one after another through a single 18x16 multiply-accumulate unit.
// The response is registered as the sequencer leaves its last step; a new sample is
// taken only once the sequencer is back in idle.
// If the receiver stalls, the finished sample waits in the output register; a further
// finished sample waits in the last sequencer step until the register frees.
// Reset (synchronous, active high) loads b0 = 1.0 and the other coefficients with zero,
// clears both delay states and drops rsp_valid. A write through the csr_ port to a
// coefficient also clears both delay states; writes to other indexes are ignored.
module biquad_highpass_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [bhp_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bhp_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                                 rsp_clipped,
   input  logic                                 csr_write_en,
   input  logic [bhp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic signed [bhp_pkg::COEF_BITS-1:0] csr_data
);

   typedef enum logic [2:0] {
      IDLE,
      MUL_B0,
      MUL_B1,
      MUL_A1,
      MUL_B2,
      MUL_A2,
      FINISH
   } seq_state_type;

   seq_state_type       state_ff, state_in;
   bhp_pkg::sample_type x_ff, x_in;
   bhp_pkg::sample_type y_ff, y_in;
   logic                clip_ff, clip_in;
   bhp_pkg::state_type  d1_ff, d1_in;
   bhp_pkg::state_type  d2_ff, d2_in;
   bhp_pkg::coef_type   coef_ff [bhp_pkg::NUM_COEFS];
   bhp_pkg::coef_type   coef_in [bhp_pkg::NUM_COEFS];
   logic                rsp_valid_ff, rsp_valid_in;
   bhp_pkg::sample_type rsp_sample_ff, rsp_sample_in;
   logic                rsp_clip_ff, rsp_clip_in;

   bhp_pkg::mac_op_type mac_op;
   bhp_pkg::acc_type    mac_result;

   bhp_pkg::acc_type    acc_shifted;
   logic [bhp_pkg::ACC_BITS-bhp_pkg::SAMPLE_BITS:0] y_head;
   logic                y_fits;
   bhp_pkg::sample_type y_sat;

   bhp_mac u_mac (
      .clock  (clock),
      .op     (mac_op),
      .result (mac_result)
   );

   function automatic bhp_pkg::state_type sat_state(input bhp_pkg::acc_type v);
      logic [bhp_pkg::ACC_BITS-bhp_pkg::STATE_BITS:0] head;
      bhp_pkg::state_type                             r;
      head = v[bhp_pkg::ACC_BITS-1:bhp_pkg::STATE_BITS-1];
      if ((&head) | (~|head)) begin
         r = v[bhp_pkg::STATE_BITS-1:0];
      end else if (v[bhp_pkg::ACC_BITS-1]) begin
         r = {1'b1, {(bhp_pkg::STATE_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(bhp_pkg::STATE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic bhp_pkg::acc_type ext_state(input bhp_pkg::state_type v);
      return {{(bhp_pkg::ACC_BITS-bhp_pkg::STATE_BITS){v[bhp_pkg::STATE_BITS-1]}}, v};
   endfunction

   // Arithmetic shift floors toward negative infinity; then clamp to the sample range.
   assign acc_shifted = mac_result >>> bhp_pkg::COEF_FRAC_BITS;
   assign y_head      = acc_shifted[bhp_pkg::ACC_BITS-1:bhp_pkg::SAMPLE_BITS-1];
   assign y_fits      = (&y_head) | (~|y_head);
   always_comb begin
      if (y_fits) begin
         y_sat = acc_shifted[bhp_pkg::SAMPLE_BITS-1:0];
      end else if (acc_shifted[bhp_pkg::ACC_BITS-1]) begin
         y_sat = {1'b1, {(bhp_pkg::SAMPLE_BITS-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(bhp_pkg::SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      clip_in       = clip_ff;
      d1_in         = d1_ff;
      d2_in         = d2_ff;
      coef_in       = coef_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_clip_in   = rsp_clip_ff;
      mac_op        = '0;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               state_in = MUL_B0;
            end
         end
         MUL_B0: begin
            mac_op   = '{en: 1'b1, sub: 1'b0, coef: coef_ff[bhp_pkg::COEF_B0],
                         data: x_ff, base: ext_state(d1_ff)};
            state_in = MUL_B1;
         end
         MUL_B1: begin
            y_in     = y_sat;
            clip_in  = ~y_fits;
            mac_op   = '{en: 1'b1, sub: 1'b0, coef: coef_ff[bhp_pkg::COEF_B1],
                         data: x_ff, base: ext_state(d2_ff)};
            state_in = MUL_A1;
         end
         MUL_A1: begin
            mac_op   = '{en: 1'b1, sub: 1'b1, coef: coef_ff[bhp_pkg::COEF_A1],
                         data: y_ff, base: mac_result};
            state_in = MUL_B2;
         end
         MUL_B2: begin
            d1_in    = sat_state(mac_result);
            mac_op   = '{en: 1'b1, sub: 1'b0, coef: coef_ff[bhp_pkg::COEF_B2],
                         data: x_ff, base: '0};
            state_in = MUL_A2;
         end
         MUL_A2: begin
            mac_op   = '{en: 1'b1, sub: 1'b1, coef: coef_ff[bhp_pkg::COEF_A2],
                         data: y_ff, base: mac_result};
            state_in = FINISH;
         end
         FINISH: begin
            // Wait here while the output register still holds an unaccepted response.
            if (!rsp_valid_ff || !rsp_stall) begin
               d2_in         = sat_state(mac_result);
               rsp_valid_in  = 1'b1;
               rsp_sample_in = y_ff;
               rsp_clip_in   = clip_ff;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      if (csr_write_en && (csr_index < bhp_pkg::CSR_INDEX_BITS'(bhp_pkg::NUM_COEFS))) begin
         coef_in[csr_index] = csr_data;
         d1_in              = '0;
         d2_in              = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                   <= IDLE;
         rsp_valid_ff               <= 1'b0;
         d1_ff                      <= '0;
         d2_ff                      <= '0;
         coef_ff[bhp_pkg::COEF_B0]  <= bhp_pkg::COEF_B0_RESET;
         coef_ff[bhp_pkg::COEF_B1]  <= '0;
         coef_ff[bhp_pkg::COEF_B2]  <= '0;
         coef_ff[bhp_pkg::COEF_A1]  <= '0;
         coef_ff[bhp_pkg::COEF_A2]  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
         coef_ff      <= coef_in;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      clip_ff       <= clip_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

   assign req_stall      = (state_ff != IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clip_ff;

   // A response appears only as the sequencer leaves its last step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == FINISH)
      else $error("response raised outside the last sequencer step");

   // A finished sample that cannot be delivered holds the sequencer and the output.
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FINISH && rsp_valid_ff && rsp_stall)
      |=> (state_ff == FINISH && $stable(rsp_sample_ff) && rsp_valid_ff))
      else $error("stalled response overwritten or sequencer moved on");

   // A coefficient write leaves both delay states cleared.
   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      (csr_write_en && (csr_index < bhp_pkg::CSR_INDEX_BITS'(bhp_pkg::NUM_COEFS)))
      |=> (d1_ff == '0 && d2_ff == '0))
      else $error("delay states not cleared by coefficient write");

   // From idle the sequencer either stays or starts with the b0 product.
   a_idle_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE) |=> (state_ff == IDLE || state_ff == MUL_B0))
      else $error("sequencer left idle to a wrong step");

endmodule

/* rtl/bhp_mac.sv */
// Shared multiply-accumulate unit: result register loads base plus or minus coef times data.
module bhp_mac (
   input  logic                clock,
   input  bhp_pkg::mac_op_type op,
   output bhp_pkg::acc_type    result
);

   logic signed [bhp_pkg::PROD_BITS-1:0] prod;
   bhp_pkg::acc_type                     prod_ext;
   bhp_pkg::acc_type                     result_ff;
   bhp_pkg::acc_type                     result_in;

   assign prod     = op.coef * op.data;
   assign prod_ext = {{(bhp_pkg::ACC_BITS-bhp_pkg::PROD_BITS){prod[bhp_pkg::PROD_BITS-1]}},
                      prod};

   always_comb begin
      if (op.sub) begin
         result_in = op.base - prod_ext;
      end else begin
         result_in = op.base + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (op.en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* tb/biquad_highpass_filter_tb.sv */
// Self-checking testbench for the biquad high-pass filter: directed table, then random phases.
`timescale 1ns / 1ps

module biquad_highpass_filter_tb;

   localparam bhp_pkg::sample_type SAMPLE_MAX =
      bhp_pkg::sample_type'(2 ** (bhp_pkg::SAMPLE_BITS - 1) - 1);
   localparam bhp_pkg::sample_type SAMPLE_MIN =
      bhp_pkg::sample_type'(-(2 ** (bhp_pkg::SAMPLE_BITS - 1)));
   localparam bhp_pkg::coef_type COEF_MAX = bhp_pkg::coef_type'(2 ** (bhp_pkg::COEF_BITS - 1) - 1);
   localparam bhp_pkg::coef_type COEF_MIN = bhp_pkg::coef_type'(-(2 ** (bhp_pkg::COEF_BITS - 1)));
   localparam bhp_pkg::coef_type COEF_ONE = bhp_pkg::COEF_B0_RESET;
   localparam logic [bhp_pkg::CSR_INDEX_BITS-1:0] INDEX_PAST_END =
      bhp_pkg::CSR_INDEX_BITS'(bhp_pkg::NUM_COEFS);
   localparam logic [bhp_pkg::CSR_INDEX_BITS-1:0] INDEX_TOP = '1;
   localparam longint STATE_MAX = (64'sd1 <<< (bhp_pkg::STATE_BITS - 1)) - 1;
   localparam longint STATE_MIN = -STATE_MAX - 1;
   localparam int DRAIN_CYCLES = 12;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES = 16;
   localparam int ITEMS_PER_PHASE = 100;

   typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_type;
   typedef enum int {MIX_WILD, MIX_STABLE, MIX_EXTREME, MIX_PARTIAL} mix_type;

   typedef struct {
      row_kind_type                       kind;
      logic [bhp_pkg::CSR_INDEX_BITS-1:0] index;
      bhp_pkg::coef_type                  value;
      bhp_pkg::sample_type                sample;
      bit                                 known;
      bhp_pkg::sample_type                want_sample;
      bit                                 want_clipped;
   } stim_row_type;

   typedef struct {
      bhp_pkg::sample_type sample;
      bit                  clipped;
   } filtered_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   bhp_pkg::sample_type                req_sample_in = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   bhp_pkg::sample_type                rsp_sample_out;
   logic                               rsp_clipped;
   logic                               csr_write_en = 1'b0;
   logic [bhp_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   bhp_pkg::coef_type                  csr_data = '0;

   // Shadow of the coefficient registers and the two delay states.
   bhp_pkg::coef_type   coef_shadow [bhp_pkg::NUM_COEFS];
   longint              state_near;
   longint              state_far;
   filtered_type        expected_samples [$];
   int                  mismatch_count = 0;
   bit                  quiet = 1'b0;
   bit                  row_known = 1'b0;
   bhp_pkg::sample_type row_sample;
   bit                  row_clipped;

   biquad_highpass_filter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);
   end

   function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                    output bit hit);
      hit = 1'b1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      hit = 1'b0;
      return v;
   endfunction

   // One step of the transposed direct form II section; the clamped output feeds back.
   function automatic filtered_type filter_sample(input bhp_pkg::sample_type x);
      filtered_type result;
      longint       xs;
      longint       acc;
      longint       y;
      longint       p_near;
      longint       p_far;
      bit           hit;
      bit           ignored;
      xs = longint'(x);
      acc = longint'(coef_shadow[bhp_pkg::COEF_B0]) * xs + state_near;
      y = clamp(acc >>> bhp_pkg::COEF_FRAC_BITS, longint'(SAMPLE_MIN), longint'(SAMPLE_MAX),
                hit);
      p_near = longint'(coef_shadow[bhp_pkg::COEF_B1]) * xs
             - longint'(coef_shadow[bhp_pkg::COEF_A1]) * y;
      p_far = longint'(coef_shadow[bhp_pkg::COEF_B2]) * xs
            - longint'(coef_shadow[bhp_pkg::COEF_A2]) * y;
      state_near = clamp(p_near + state_far, STATE_MIN, STATE_MAX, ignored);
      state_far = clamp(p_far, STATE_MIN, STATE_MAX, ignored);
      result.sample = bhp_pkg::sample_type'(y);
      result.clipped = hit;
      return result;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      filtered_type want;
      if (reset) begin
         coef_shadow[bhp_pkg::COEF_B0] = bhp_pkg::COEF_B0_RESET;
         for (int i = 1; i < bhp_pkg::NUM_COEFS; i++) coef_shadow[i] = '0;
         state_near = 0;
         state_far = 0;
      end else begin
         if (csr_write_en && csr_index < bhp_pkg::NUM_COEFS) begin
            coef_shadow[csr_index] = csr_data;
            state_near = 0;
            state_far = 0;
         end
         if (req_valid && !req_stall) begin
            want = filter_sample(req_sample_in);
            if (row_known) begin
               want.sample = row_sample;
               want.clipped = row_clipped;
            end
            expected_samples.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected response, sample", longint'(rsp_sample_out), 0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want.sample)
                  report_mismatch("sample_out", longint'(rsp_sample_out),
                                  longint'(want.sample));
               if (rsp_clipped !== want.clipped)
                  report_mismatch("clipped", longint'(rsp_clipped), longint'(want.clipped));
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_sample(input bhp_pkg::sample_type x);
      if (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < 50);
      end
      req_valid <= 1'b1;
      req_sample_in <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_filter();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_coef(input logic [bhp_pkg::CSR_INDEX_BITS-1:0] index,
                             input bhp_pkg::coef_type value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
   endtask

   task automatic release_csr();
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic stim_row_type known_row(input bhp_pkg::sample_type x,
                                              input bhp_pkg::sample_type y,
                                              input bit clipped);
      stim_row_type row;
      row = '{ROW_SAMPLE, '0, '0, x, 1'b1, y, clipped};
      return row;
   endfunction

   function automatic stim_row_type sample_row(input bhp_pkg::sample_type x);
      stim_row_type row;
      row = '{ROW_SAMPLE, '0, '0, x, 1'b0, '0, 1'b0};
      return row;
   endfunction

   function automatic stim_row_type write_row(input logic [bhp_pkg::CSR_INDEX_BITS-1:0] index,
                                              input bhp_pkg::coef_type value);
      stim_row_type row;
      row = '{ROW_WRITE, index, value, '0, 1'b0, '0, 1'b0};
      return row;
   endfunction

   function automatic bhp_pkg::sample_type pick_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return bhp_pkg::sample_type'(int'($urandom_range(0, 511)) - 256);
         default: return bhp_pkg::sample_type'($urandom);
      endcase
   endfunction

   function automatic bhp_pkg::coef_type coef_for(input mix_type style, input int i);
      case (style)
         MIX_STABLE: begin
            // Keeping |a1| + |a2| below one leaves the feedback loop stable.
            if (i == bhp_pkg::COEF_A1)
               return bhp_pkg::coef_type'(int'($urandom_range(0, 65535)) - 32768);
            if (i == bhp_pkg::COEF_A2)
               return bhp_pkg::coef_type'(int'($urandom_range(0, 32767)) - 16384);
            return bhp_pkg::coef_type'($urandom);
         end
         MIX_EXTREME: begin
            case ($urandom_range(0, 3))
               0: return COEF_MAX;
               1: return COEF_MIN;
               2: return '0;
               default: return COEF_ONE;
            endcase
         end
         default: return bhp_pkg::coef_type'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      stim_row_type rows [$];
      mix_type      style;

      // Identity after reset, then b0 at its extremes and its smallest step.
      rows.push_back(known_row('0, '0, 1'b0));
      rows.push_back(known_row(SAMPLE_MAX, SAMPLE_MAX, 1'b0));
      rows.push_back(known_row(SAMPLE_MIN, SAMPLE_MIN, 1'b0));
      rows.push_back(known_row(bhp_pkg::sample_type'(1), bhp_pkg::sample_type'(1), 1'b0));
      rows.push_back(known_row(bhp_pkg::sample_type'(-1), bhp_pkg::sample_type'(-1), 1'b0));
      rows.push_back(write_row(bhp_pkg::COEF_B0, COEF_MAX));
      rows.push_back(known_row(SAMPLE_MAX, SAMPLE_MAX, 1'b1));
      rows.push_back(known_row(SAMPLE_MIN, SAMPLE_MIN, 1'b1));
      rows.push_back(known_row('0, '0, 1'b0));
      rows.push_back(write_row(bhp_pkg::COEF_B0, COEF_MIN));
      rows.push_back(known_row(SAMPLE_MIN, SAMPLE_MAX, 1'b1));
      rows.push_back(known_row(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
      rows.push_back(known_row(bhp_pkg::sample_type'(1), bhp_pkg::sample_type'(-2), 1'b0));
      // With b0 at one step the shift must round towards minus infinity.
      rows.push_back(write_row(bhp_pkg::COEF_B0, bhp_pkg::coef_type'(1)));
      rows.push_back(known_row(bhp_pkg::sample_type'(-1), bhp_pkg::sample_type'(-1), 1'b0));
      rows.push_back(known_row(SAMPLE_MAX, '0, 1'b0));
      rows.push_back(known_row(SAMPLE_MIN, bhp_pkg::sample_type'(-1), 1'b0));
      rows.push_back(write_row(bhp_pkg::COEF_B0, COEF_ONE));
      rows.push_back(write_row(bhp_pkg::COEF_B1, COEF_MAX));
      rows.push_back(write_row(bhp_pkg::COEF_B2, COEF_MIN));
      rows.push_back(write_row(bhp_pkg::COEF_A1, COEF_MIN));
      rows.push_back(write_row(bhp_pkg::COEF_A2, COEF_MAX));
      rows.push_back(sample_row(SAMPLE_MAX));
      rows.push_back(sample_row(SAMPLE_MIN));
      rows.push_back(sample_row('0));
      rows.push_back(sample_row(bhp_pkg::sample_type'(12345)));
      rows.push_back(sample_row(bhp_pkg::sample_type'(-1)));
      // Writes past the last register must leave the delay states alone.
      rows.push_back(write_row(INDEX_PAST_END, bhp_pkg::coef_type'(1000)));
      rows.push_back(write_row(INDEX_TOP, COEF_MIN));
      rows.push_back(sample_row(SAMPLE_MAX));
      rows.push_back(sample_row(bhp_pkg::sample_type'(-20000)));

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (rows[r]) begin
         if (rows[r].kind == ROW_WRITE) begin
            drain_filter();
            write_coef(rows[r].index, rows[r].value);
            release_csr();
         end else begin
            row_known = rows[r].known;
            row_sample = rows[r].want_sample;
            row_clipped = rows[r].want_clipped;
            send_sample(rows[r].sample);
         end
      end
      row_known = 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         style = mix_type'(phase % 4);
         drain_filter();
         if (style == MIX_PARTIAL) begin
            repeat ($urandom_range(1, 3))
               write_coef(bhp_pkg::CSR_INDEX_BITS'($urandom_range(0,
                             2 ** bhp_pkg::CSR_INDEX_BITS - 1)),
                          bhp_pkg::coef_type'($urandom));
         end else begin
            for (int i = 0; i < bhp_pkg::NUM_COEFS; i++)
               write_coef(bhp_pkg::CSR_INDEX_BITS'(i), coef_for(style, i));
         end
         release_csr();
         quiet = (phase == 5 || phase == 6);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Now and then the sender holds off until every request has been answered.
            if (phase % 5 == 2 && n == ITEMS_PER_PHASE / 2) drain_filter();
            send_sample(pick_sample());
         end
      end

      drain_filter();
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
